[hw/rtl/cgpb_pkg.sv]
// Package for the clipped glyph palette blitter: glyph and palette geometry,
// opcodes, register indexes, state encoding and the command and pixel word types.
// Depends on nothing; imported by clipped_glyph_palette_blitter_top.
`default_nettype none

package cgpb_pkg;

  // Glyph geometry and store sizes. NUM_GLYPHS and NUM_COLOURS are powers of two.
  localparam int GLYPH_W      = 8;
  localparam int GLYPH_H      = 8;
  localparam int NUM_GLYPHS   = 256;
  localparam int NUM_COLOURS  = 256;
  localparam int COLOUR_GRAN  = 2;
  localparam int GLYPH_DEPTH  = 16384;
  localparam int PAL_DEPTH    = 512;
  localparam int MAX_RESULTS  = 64;

  localparam int GLYPH_AW = $clog2(GLYPH_DEPTH);
  localparam int PAL_AW   = $clog2(PAL_DEPTH);
  localparam int ROW_W    = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;
  localparam int COL_W    = (GLYPH_W > 1) ? $clog2(GLYPH_W) : 1;
  localparam int CNT_W    = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  // APB register file: seven 32-bit registers at byte addresses 0..24.
  localparam int ADDR_W = 5;

  localparam logic [11:0] DEST_WIDTH_RST  = 12'd640;
  localparam logic [11:0] DEST_HEIGHT_RST = 12'd200;
  localparam logic [10:0] CLIP_LO_RST     = 11'd0;
  localparam logic [10:0] CLIP_HI_RST     = 11'd2047;

  typedef enum logic [1:0] {
    OP_LOAD_GLYPH   = 2'd0,
    OP_LOAD_PALETTE = 2'd1,
    OP_DRAW         = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MODE_FULL   = 2'd0,
    MODE_SKIP   = 2'd1,
    MODE_DOUBLE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_DEST_WIDTH  = 3'd0,
    REG_DEST_HEIGHT = 3'd1,
    REG_CLIP_LEFT   = 3'd2,
    REG_CLIP_RIGHT  = 3'd3,
    REG_CLIP_TOP    = 3'd4,
    REG_CLIP_BOTTOM = 3'd5,
    REG_BLIT_MODE   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CLIP = 2'd1,
    ST_DRAW = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [13:0]        load_address;
    logic [15:0]        load_value;
    logic [7:0]         glyph_code;
    logic [7:0]         colour_index;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
  } cmd_t;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [7:0]  pen;
    logic        last;
  } pixel_t;

endpackage

`default_nettype wire

[hw/rtl/clipped_glyph_palette_blitter_top.sv]
// Clipped glyph blitter with palette lookup: clip stage, pixel sequencer,
// glyph store and palette store, APB register file.
// Depends on cgpb_pkg.
`default_nettype none

// A command word is taken when start is high and busy is low. Glyph and
// palette loads leave busy low. A draw holds busy through its clip state and
// its draw state; an empty clip holds busy for the clip state only. The
// sequencer reads the glyph store once per pixel and each glyph byte then
// addresses the palette store, so every pixel word appears on result with
// strobe once the glyph read and the palette read are registered, one word
// per cycle, in row order, last set on the final word of the draw.
// Words are shown for exactly one cycle and cannot be held off. Write the
// registers only when no draw is running and all its words are out.
module clipped_glyph_palette_blitter_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire cgpb_pkg::cmd_t               cmd,
  output      logic                         strobe,
  output      cgpb_pkg::pixel_t             result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cgpb_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output      logic [31:0]                  prdata,
  output      logic                         pready
);
  import cgpb_pkg::*;

  // Registers
  logic [11:0] dest_width;
  logic [11:0] dest_height;
  logic [10:0] clip_left;
  logic [10:0] clip_right;
  logic [10:0] clip_top;
  logic [10:0] clip_bottom;
  logic [1:0]  blit_mode;

  // Command hold
  logic [7:0]         code_q;
  logic [7:0]         colour_q;
  logic signed [11:0] ox_q;
  logic signed [11:0] oy_q;

  // Sequencer
  state_t            state;
  state_t            state_next;
  logic [10:0]       sx_q;
  logic [10:0]       ex_q;
  logic [10:0]       ey_q;
  logic [10:0]       cur_x;
  logic [10:0]       line_y;
  logic              dbl_phase;
  logic [ROW_W-1:0]  grow;
  logic [CNT_W-1:0]  count;
  logic              step;

  // Pipeline
  logic        s1_valid;
  logic [10:0] s1_x;
  logic [10:0] s1_y;
  logic        s1_last;
  logic [10:0] out_x;
  logic [10:0] out_y;
  logic        out_last;

  // Stores
  logic [7:0]  glyph_mem [GLYPH_DEPTH];
  logic [15:0] pal_mem   [PAL_DEPTH];
  logic [7:0]  glyph_rdata;
  logic [15:0] pal_rdata;
  logic [GLYPH_AW-1:0] glyph_raddr;
  logic [PAL_AW-1:0]   pal_raddr;

  logic accept;
  logic cfg_write;

  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // ---------------- register file ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width  <= DEST_WIDTH_RST;
      dest_height <= DEST_HEIGHT_RST;
      clip_left   <= CLIP_LO_RST;
      clip_right  <= CLIP_HI_RST;
      clip_top    <= CLIP_LO_RST;
      clip_bottom <= CLIP_HI_RST;
      blit_mode   <= MODE_FULL;
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[ADDR_W-1:2]))
        REG_DEST_WIDTH:  dest_width  <= pwdata[11:0];
        REG_DEST_HEIGHT: dest_height <= pwdata[11:0];
        REG_CLIP_LEFT:   clip_left   <= pwdata[10:0];
        REG_CLIP_RIGHT:  clip_right  <= pwdata[10:0];
        REG_CLIP_TOP:    clip_top    <= pwdata[10:0];
        REG_CLIP_BOTTOM: clip_bottom <= pwdata[10:0];
        REG_BLIT_MODE:   blit_mode   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[ADDR_W-1:2]))
      REG_DEST_WIDTH:  prdata = {20'd0, dest_width};
      REG_DEST_HEIGHT: prdata = {20'd0, dest_height};
      REG_CLIP_LEFT:   prdata = {21'd0, clip_left};
      REG_CLIP_RIGHT:  prdata = {21'd0, clip_right};
      REG_CLIP_TOP:    prdata = {21'd0, clip_top};
      REG_CLIP_BOTTOM: prdata = {21'd0, clip_bottom};
      REG_BLIT_MODE:   prdata = {30'd0, blit_mode};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------- command hold ----------------
  always_ff @(posedge clk) begin
    if (accept && cmd.operation == OP_DRAW) begin
      code_q   <= 8'(32'(cmd.glyph_code) % NUM_GLYPHS);
      colour_q <= 8'(32'(cmd.colour_index) % NUM_COLOURS);
      ox_q     <= cmd.pos_x;
      oy_q     <= cmd.pos_y;
    end
  end

  // ---------------- clip ----------------
  logic signed [12:0] ox13, oy13;
  logic signed [12:0] sx_c, ex_c, sy_c, ey_c;
  logic signed [12:0] lim_r, lim_b;
  logic               clip_empty;

  always_comb begin
    ox13 = 13'(ox_q);
    oy13 = 13'(oy_q);

    // left edge: max(origin, 0, clip_left); right: min(end, width-1, clip_right)
    sx_c = (ox13 < 13'sd0) ? 13'sd0 : ox13;
    if (sx_c < $signed({2'b00, clip_left})) sx_c = $signed({2'b00, clip_left});
    ex_c  = ox13 + 13'(GLYPH_W - 1);
    lim_r = $signed({1'b0, dest_width}) - 13'sd1;
    if (ex_c > lim_r) ex_c = lim_r;
    if (ex_c > $signed({2'b00, clip_right})) ex_c = $signed({2'b00, clip_right});

    sy_c = (oy13 < 13'sd0) ? 13'sd0 : oy13;
    if (sy_c < $signed({2'b00, clip_top})) sy_c = $signed({2'b00, clip_top});
    ey_c  = oy13 + 13'(GLYPH_H - 1);
    lim_b = $signed({1'b0, dest_height}) - 13'sd1;
    if (ey_c > lim_b) ey_c = lim_b;
    if (ey_c > $signed({2'b00, clip_bottom})) ey_c = $signed({2'b00, clip_bottom});

    clip_empty = (sx_c > ex_c) || (sy_c > ey_c);
  end

  // ---------------- pixel sequencer ----------------
  logic              skip, dbl;
  logic              x_end, go_double, line_done, cap, pix_last;
  logic [10:0]       y_now;
  logic [11:0]       y_next_base;
  logic [12:0]       col_wide;
  logic [COL_W-1:0]  col;
  logic [31:0]       gaddr_wide;
  logic [12:0]       grow_wide;

  always_comb begin
    skip = (blit_mode != MODE_FULL);
    dbl  = blit_mode[1];  // doubled mode and the unused code above it

    x_end       = (cur_x == ex_q);
    y_now       = dbl_phase ? line_y + 11'd1 : line_y;
    y_next_base = {1'b0, line_y} + (skip ? 12'd2 : 12'd1);
    go_double   = dbl && !dbl_phase && ({1'b0, line_y} + 12'd1 <= {1'b0, ey_q});
    line_done   = !go_double && (y_next_base > {1'b0, ey_q});
    cap         = (count == CNT_W'(MAX_RESULTS - 1));
    pix_last    = (x_end && line_done) || cap;

    col_wide    = $signed({2'b00, cur_x}) - ox13;
    col         = col_wide[COL_W-1:0];
    gaddr_wide  = (32'(code_q) * 32'(GLYPH_H) + 32'(grow)) * 32'(GLYPH_W) + 32'(col);
    glyph_raddr = gaddr_wide[GLYPH_AW-1:0];
    grow_wide   = sy_c - oy13;
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLIP) begin
      sx_q      <= sx_c[10:0];
      ex_q      <= ex_c[10:0];
      ey_q      <= ey_c[10:0];
      cur_x     <= sx_c[10:0];
      line_y    <= sy_c[10:0];
      dbl_phase <= 1'b0;
      grow      <= grow_wide[ROW_W-1:0];
      count     <= '0;
    end else if (step) begin
      count <= count + CNT_W'(1);
      if (!x_end) begin
        cur_x <= cur_x + 11'd1;
      end else begin
        cur_x <= sx_q;
        if (go_double) begin
          dbl_phase <= 1'b1;
        end else begin
          dbl_phase <= 1'b0;
          line_y    <= y_next_base[10:0];
          grow      <= grow + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd.operation == OP_DRAW) state_next = ST_CLIP;
      end
      ST_CLIP: begin
        state_next = clip_empty ? ST_IDLE : ST_DRAW;
      end
      ST_DRAW: begin
        if (pix_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    step = (state == ST_DRAW);
  end

  // ---------------- stores ----------------
  // Loads land only while idle; a palette read of a draw's final word in the
  // same cycle as a palette load still sees the old entry.
  always_ff @(posedge clk) begin
    if (accept && cmd.operation == OP_LOAD_GLYPH) begin
      glyph_mem[cmd.load_address[GLYPH_AW-1:0]] <= cmd.load_value[7:0];
    end
    if (step) begin
      glyph_rdata <= glyph_mem[glyph_raddr];
    end
  end

  logic [31:0] paddr_wide;
  always_comb begin
    paddr_wide = 32'(COLOUR_GRAN) * 32'(colour_q) + 32'(glyph_rdata);
    pal_raddr  = paddr_wide[PAL_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.operation == OP_LOAD_PALETTE) begin
      pal_mem[cmd.load_address[PAL_AW-1:0]] <= cmd.load_value;
    end
    if (s1_valid) begin
      pal_rdata <= pal_mem[pal_raddr];
    end
  end

  // ---------------- pixel pipeline ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      s1_valid <= step;
      strobe   <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_x     <= cur_x;
    s1_y     <= y_now;
    s1_last  <= pix_last;
    out_x    <= s1_x;
    out_y    <= s1_y;
    out_last <= s1_last;
  end

  assign result = '{pixel_x: out_x, pixel_y: out_y, pen: pal_rdata[7:0], last: out_last};

`ifndef SYNTHESIS
  a_strobe_follows_fetch: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(s1_valid))
    else $error("pixel word without a palette fetch");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("pixel word right after the last word of a draw");

  a_x_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW) |-> (cur_x <= ex_q))
    else $error("column ran past the clipped right edge");

  a_double_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW && dbl_phase) |-> (line_y < ey_q))
    else $error("doubled line below the clipped bottom");

  a_no_step_idle: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(state == ST_DRAW))
    else $error("glyph fetch outside a draw");
`endif

endmodule

`default_nettype wire
